// ===== src/ris_pkg.sv =====
// Shared types and constants for the record insertion sorter.
`default_nettype none

package ris_pkg;

   localparam int CAPACITY   = 32;
   localparam int NAME_BYTES = 8;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // keeps the top NAME_BYTES bytes of the key, the rest reads as zero
   localparam logic [63:0] KEY_MASK = ~64'h0 << ((8 - NAME_BYTES) * 8);

   typedef struct packed {
      logic [63:0] name_key;
      logic [15:0] rec_id;
      logic [7:0]  age;
      logic [9:0]  height;
      logic [9:0]  weight;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] name_key_res;
      logic [15:0] rec_id_res;
      logic [7:0]  age_res;
      logic [9:0]  height_res;
      logic [9:0]  weight_res;
      logic        last_out;
      logic        dropped;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [15:0] rec_id;
      logic [7:0]  age;
      logic [9:0]  height;
      logic [9:0]  weight;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } tbl_wr_type;

endpackage

`default_nettype wire

// ===== src/ris_table.sv =====
// Record table: one write port, one registered read port.
`default_nettype none

module ris_table (
   input  logic                       clock,
   input  ris_pkg::tbl_wr_type        wr,
   input  logic [ris_pkg::ADDR_W-1:0] rd_addr,
   output ris_pkg::entry_type         rd_data
);
   import ris_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/record_insertion_sorter.sv =====
// Top level: stable insertion sort of records, emitted in key order on the last word.
`default_nettype none

// Records enter one per start while busy is low. Each record is placed into a
// table with one write and one registered read port by one compare-and-move
// step per cycle: busy stays high from the accept while each stored entry with
// a larger key moves up one slot and the record is written. A word marked last
// then passes through a load state that primes the table read, and the n stored
// records follow on rsp_strobe, one per cycle, the first registered out of the
// emit state that follows the load; busy falls as the last one is registered.
// A table-full record is discarded without raising busy (a last one goes
// straight to the read priming) and every result of that run carries dropped.
// The receiver cannot stall: results must be taken as shown.
module record_insertion_sorter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ris_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ris_pkg::rsp_type rsp_item
);
   import ris_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   entry_type         new_ff, new_in;
   logic              last_ff, last_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   tbl_wr_type        wr;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   ris_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr.en         = 1'b0;
      wr.addr       = pos_ff;
      wr.data       = new_ff;
      rd_addr       = pos_ff - ADDR_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_in.key    = req_item.name_key & KEY_MASK;
               new_in.rec_id = req_item.rec_id;
               new_in.age    = req_item.age;
               new_in.height = req_item.height;
               new_in.weight = req_item.weight;
               last_in       = req_item.is_last;
               if (count_ff == CNT_W'(CAPACITY)) begin
                  overflow_in = 1'b1;
                  if (req_item.is_last) begin
                     state_in = ST_LOAD;
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  pos_in   = count_ff[ADDR_W-1:0];
                  rd_addr  = count_ff[ADDR_W-1:0] - ADDR_W'(1);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // rd_data holds the entry just below pos
            wr.en = 1'b1;
            if (new_ff.key < rd_data.key) begin
               wr.data = rd_data;
               pos_in  = pos_ff - ADDR_W'(1);
               rd_addr = pos_ff - ADDR_W'(2);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = last_ff ? ST_LOAD : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr.en    = 1'b1;
            wr.addr  = '0;
            count_in = count_ff + CNT_W'(1);
            state_in = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            rd_addr  = '0;
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rd_addr                  = pos_ff + ADDR_W'(1);
            pos_in                   = pos_ff + ADDR_W'(1);
            rsp_strobe_in            = 1'b1;
            rsp_item_in.name_key_res = rd_data.key;
            rsp_item_in.rec_id_res   = rd_data.rec_id;
            rsp_item_in.age_res      = rd_data.age;
            rsp_item_in.height_res   = rd_data.height;
            rsp_item_in.weight_res   = rd_data.weight;
            rsp_item_in.dropped      = overflow_ff;
            rsp_item_in.last_out     = (CNT_W'(pos_ff) + CNT_W'(1)) == count_ff;
            if (rsp_item_in.last_out) begin
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff      <= pos_in;
      new_ff      <= new_in;
      last_ff     <= last_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> pos_ff != '0)
      else $error("shift step at slot zero");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_item_ff.last_out |-> count_ff == '0 && !overflow_ff)
      else $error("table not emptied after final word");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> count_ff != '0)
      else $error("output run started on empty table");

endmodule

`default_nettype wire
